// ===== rtl/core/gcig_pkg.sv =====
package gcig_pkg;

    // Field widths of the configuration registers and the results
    localparam int DIMS_W      = 2;
    localparam int CELLS_W     = 10;
    localparam int OFFSET_W    = 31;
    localparam int INDEX_W     = 32;
    localparam int NUM_CORNERS = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMS       = 3'd0,
        REG_CELLS_DIM0 = 3'd1,
        REG_CELLS_DIM1 = 3'd2,
        REG_CELLS_DIM2 = 3'd3,
        REG_OFFSET     = 3'd4
    } t_cfg_reg;

    // Dimension count in use: zero acts as one, too large acts as the maximum
    function automatic logic [DIMS_W-1:0] eff_dims(input logic [DIMS_W-1:0] dims,
                                                   input int max_dims);
        logic [DIMS_W-1:0] n;
        n = dims;
        if (n == '0) begin
            n = DIMS_W'(1);
        end
        if (int'(n) > max_dims) begin
            n = DIMS_W'(max_dims);
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/gcig_walker.sv =====
module gcig_walker import gcig_pkg::*; #(
    parameter int MAX_DIMS        = 3,
    parameter int CELL_COUNT_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  logic                       i_restart,
    input  logic [DIMS_W-1:0]          i_nd,
    input  logic [CELL_COUNT_BITS-1:0] i_cells [MAX_DIMS],
    output logic [CELL_COUNT_BITS-1:0] o_coord [MAX_DIMS],
    output logic                       o_last
);

    localparam int CW = CELL_COUNT_BITS;

    logic [CW-1:0] r_coord [MAX_DIMS];
    logic [CW-1:0] n_coord [MAX_DIMS];
    logic [CW:0]   w_inc   [MAX_DIMS];

    // Current cell (after rewind) and the carry chain of the advance
    always_comb begin
        logic carry;
        carry = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            if (i_restart || (DIMS_W'(d) >= i_nd)) begin
                o_coord[d] = '0;
            end else begin
                o_coord[d] = r_coord[d];
            end
        end
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_inc[d]   = {1'b0, o_coord[d]} + (CW+1)'(1);
            n_coord[d] = o_coord[d];
            if ((DIMS_W'(d) < i_nd) && carry) begin
                if (w_inc[d] >= {1'b0, i_cells[d]}) begin
                    n_coord[d] = '0;
                end else begin
                    n_coord[d] = w_inc[d][CW-1:0];
                    carry      = 1'b0;
                end
            end
        end
        o_last = carry;
    end

    // Coordinate state moves on every transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_coord[d] <= '0;
            end
        end else if (i_step) begin
            r_coord <= n_coord;
        end
    end

endmodule

// ===== rtl/core/grid_cell_corner_index_generator_unit.sv =====
// An input transfer passes through the capture, stride-product and base-sum registers into the output register.
// Throughput: one cell per cycle while the output is not stalled; the walk counter and four pipeline stages
// (capture, stride products, base sum, corner adds) each take a new item every cycle unless held by a stall.
// Reset (synchronous, active low) clears the walk to cell zero, empties the pipeline
// and loads dims 3, all cell counts 1 and vertex offset 0.
// Strides are registered from the configuration registers, and corner offsets are registered from the strides.
module grid_cell_corner_index_generator_unit import gcig_pkg::*; #(
    parameter int MAX_DIMS        = 3,
    parameter int CELL_COUNT_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_restart,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [INDEX_W-1:0]    o_corner0,
    output logic [INDEX_W-1:0]    o_corner1,
    output logic [INDEX_W-1:0]    o_corner2,
    output logic [INDEX_W-1:0]    o_corner3,
    output logic [INDEX_W-1:0]    o_corner4,
    output logic [INDEX_W-1:0]    o_corner5,
    output logic [INDEX_W-1:0]    o_corner6,
    output logic [INDEX_W-1:0]    o_corner7,
    output logic                  o_last_cell
);

    localparam int CW       = CELL_COUNT_BITS;
    localparam int STRIDE_W = CW * (MAX_DIMS - 1) + 1;
    localparam int DELTA_W  = STRIDE_W + 2;
    localparam int PROD_W   = STRIDE_W + CW;

    // Configuration registers
    logic [DIMS_W-1:0]   r_dims;
    logic [CELLS_W-1:0]  r_cells [3];
    logic [OFFSET_W-1:0] r_offset;

    // Derived geometry
    logic [CW-1:0]       w_ec     [MAX_DIMS];
    logic [DIMS_W-1:0]   w_nd;
    logic [STRIDE_W-1:0] n_stride [MAX_DIMS];
    logic [STRIDE_W-1:0] r_stride [MAX_DIMS];
    logic [DELTA_W-1:0]  n_delta  [NUM_CORNERS];
    logic [DELTA_W-1:0]  r_delta  [NUM_CORNERS];
    logic [DIMS_W-1:0]   r_nd_s;
    logic [DIMS_W-1:0]   r_nd_d;

    // Pipeline
    logic                w_s1_rdy, w_s2_rdy, w_s3_rdy, w_s4_rdy, w_in_xfer;
    logic                r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic [CW-1:0]       w_coord  [MAX_DIMS];
    logic                w_last;
    logic [CW-1:0]       r_s1_coord [MAX_DIMS];
    logic                r_s1_last;
    logic [PROD_W-1:0]   r_s2_prod  [MAX_DIMS];
    logic                r_s2_last;
    logic [INDEX_W-1:0]  n_base;
    logic [INDEX_W-1:0]  r_s3_base;
    logic                r_s3_last;
    logic [INDEX_W-1:0]  n_corner [NUM_CORNERS];
    logic [INDEX_W-1:0]  r_corner [NUM_CORNERS];
    logic                r_last;

    // Configuration writes; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims     <= DIMS_W'(3);
            r_cells[0] <= CELLS_W'(1);
            r_cells[1] <= CELLS_W'(1);
            r_cells[2] <= CELLS_W'(1);
            r_offset   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_DIMS:       r_dims     <= i_cfg_data[DIMS_W-1:0];
                REG_CELLS_DIM0: r_cells[0] <= i_cfg_data[CELLS_W-1:0];
                REG_CELLS_DIM1: r_cells[1] <= i_cfg_data[CELLS_W-1:0];
                REG_CELLS_DIM2: r_cells[2] <= i_cfg_data[CELLS_W-1:0];
                REG_OFFSET:     r_offset   <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective counts: low bits only, zero acts as one
    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_ec[d] = r_cells[d][CW-1:0];
            if (w_ec[d] == '0) begin
                w_ec[d] = CW'(1);
            end
        end
    end

    assign w_nd = eff_dims(r_dims, MAX_DIMS);

    // Strides: product of (cells + 1) over the lower dimensions
    always_comb begin
        n_stride[0] = STRIDE_W'(1);
        for (int d = 1; d < MAX_DIMS; d++) begin
            n_stride[d] = STRIDE_W'(n_stride[d-1] * ((CW+1)'(w_ec[d-1]) + (CW+1)'(1)));
        end
    end

    // Corner offsets from the base vertex
    always_comb begin
        for (int j = 0; j < NUM_CORNERS; j++) begin
            n_delta[j] = '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                if (((j >> d) & 1) == 1) begin
                    n_delta[j] = n_delta[j] + DELTA_W'(r_stride[d]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_stride <= n_stride;
        r_nd_s   <= w_nd;
        r_delta  <= n_delta;
        r_nd_d   <= r_nd_s;
    end

    // Walk counter
    gcig_walker #(
        .MAX_DIMS        (MAX_DIMS),
        .CELL_COUNT_BITS (CELL_COUNT_BITS)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_in_xfer),
        .i_restart (i_restart),
        .i_nd      (w_nd),
        .i_cells   (w_ec),
        .o_coord   (w_coord),
        .o_last    (w_last)
    );

    // Stage flow control
    assign w_s4_rdy   = !r_s4_v || !i_out_stall;
    assign w_s3_rdy   = !r_s3_v || w_s4_rdy;
    assign w_s2_rdy   = !r_s2_v || w_s3_rdy;
    assign w_s1_rdy   = !r_s1_v || w_s2_rdy;
    assign o_in_stall = !w_s1_rdy;
    assign w_in_xfer  = i_in_valid && w_s1_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (w_s1_rdy) begin
                r_s1_v <= i_in_valid;
            end
            if (w_s2_rdy) begin
                r_s2_v <= r_s1_v;
            end
            if (w_s3_rdy) begin
                r_s3_v <= r_s2_v;
            end
            if (w_s4_rdy) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    // Base vertex index of the cell
    always_comb begin
        n_base = INDEX_W'(r_offset);
        for (int d = 0; d < MAX_DIMS; d++) begin
            n_base = n_base + INDEX_W'(r_s2_prod[d]);
        end
    end

    // Corner indexes; corners from 2^dims upward read zero
    always_comb begin
        for (int j = 0; j < NUM_CORNERS; j++) begin
            if ((4'(j) >> r_nd_d) == 4'd0) begin
                n_corner[j] = r_s3_base + INDEX_W'(r_delta[j]);
            end else begin
                n_corner[j] = '0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_coord <= w_coord;
            r_s1_last  <= w_last;
        end
        if (w_s2_rdy && r_s1_v) begin
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_s2_prod[d] <= PROD_W'(r_stride[d]) * PROD_W'(r_s1_coord[d]);
            end
            r_s2_last <= r_s1_last;
        end
        if (w_s3_rdy && r_s2_v) begin
            r_s3_base <= n_base;
            r_s3_last <= r_s2_last;
        end
        if (w_s4_rdy && r_s3_v) begin
            r_corner <= n_corner;
            r_last   <= r_s3_last;
        end
    end

    assign o_out_valid = r_s4_v;
    assign o_corner0   = r_corner[0];
    assign o_corner1   = r_corner[1];
    assign o_corner2   = r_corner[2];
    assign o_corner3   = r_corner[3];
    assign o_corner4   = r_corner[4];
    assign o_corner5   = r_corner[5];
    assign o_corner6   = r_corner[6];
    assign o_corner7   = r_corner[7];
    assign o_last_cell = r_last;

    // Input stalls only when every stage holds an item and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_v && r_s2_v && r_s3_v && r_s4_v && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // Corner one always sits one vertex above corner zero along dimension zero
    a_corner1_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_corner1 == o_corner0 + 32'd1))
        else $error("corner one is not corner zero plus one");

    // An item in the base stage moves into an empty output register
    a_s4_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_v && !r_s4_v) |=> r_s4_v)
        else $error("item lost between base stage and output register");

endmodule
